// File: hw/rtl/wsd_pkg.sv
// package for the websocket frame deframer: parse phases, the word passed
// from the header parser to the unmask stage, and framing constants
// no dependencies
`default_nettype none

package wsd_pkg;

   localparam int ByteW = 8;
   localparam int LenW  = 63;
   localparam int KeyW  = 32;
   localparam int LeftW = 4;

   localparam logic [6:0] Len7Ext16 = 7'd126;
   localparam logic [6:0] Len7Ext64 = 7'd127;

   localparam logic [LeftW-1:0] Ext16Bytes = 4'd2;
   localparam logic [LeftW-1:0] Ext64Bytes = 4'd8;
   localparam logic [LeftW-1:0] KeyBytes   = 4'd4;

   typedef enum logic [2:0] {
      PH_HDR0  = 3'd0,
      PH_HDR1  = 3'd1,
      PH_EXT16 = 3'd2,
      PH_EXT64 = 3'd3,
      PH_KEY   = 3'd4,
      PH_DATA  = 3'd5
   } phase_type;

   // one result in the making: raw byte plus the key byte it gets xored with
   typedef struct packed {
      logic [ByteW-1:0] data;
      logic [ByteW-1:0] key;
      logic             has_byte;
      logic             fin_bit;
      logic             was_masked;
      logic [LenW-1:0]  frame_length;
      logic             last_in_frame;
      logic             length_error;
   } item_type;

endpackage

`default_nettype wire

// File: hw/rtl/wsd_front.sv
// header parser: walks the frame header one byte at a time and pushes one
// item per payload byte (or one marker per empty frame) into the queue
// depends on wsd_pkg
`default_nettype none

module wsd_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_accept,
   input  wire logic [wsd_pkg::ByteW-1:0]   in_byte,
   output logic                             push,
   output wsd_pkg::item_type                item
);

   wsd_pkg::phase_type phase_ff, phase_in;
   logic                        fin_ff, fin_in;
   logic                        mask_ff, mask_in;
   logic [wsd_pkg::LeftW-1:0]   left_ff, left_in;
   logic [wsd_pkg::LenW-1:0]    len_ff, len_in;
   logic [wsd_pkg::KeyW-1:0]    key_ff, key_in;
   logic [wsd_pkg::LenW-1:0]    idx_ff, idx_in;
   logic                        err_ff, err_in;

   logic [6:0]                  len7;
   logic [wsd_pkg::LeftW-1:0]   left_dec;
   logic [wsd_pkg::LenW-1:0]    len_shift;
   logic [wsd_pkg::LenW-1:0]    idx_inc;
   logic                        data_last;
   logic [wsd_pkg::ByteW-1:0]   key_byte;

   assign len7      = in_byte[6:0];
   assign left_dec  = (left_ff != '0) ? left_ff - 1'b1 : left_ff;
   assign len_shift = {len_ff[wsd_pkg::LenW-9:0], in_byte};
   assign idx_inc   = idx_ff + 1'b1;
   assign data_last = (idx_inc >= len_ff);

   // first key byte sits in the top byte
   always_comb begin
      unique case (idx_ff[1:0])
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (in_accept) begin
         unique case (phase_ff)
            wsd_pkg::PH_HDR1: begin
               if (len7 == wsd_pkg::Len7Ext16) begin
                  phase_in = wsd_pkg::PH_EXT16;
               end else if (len7 == wsd_pkg::Len7Ext64) begin
                  phase_in = wsd_pkg::PH_EXT64;
               end else if (in_byte[7]) begin
                  phase_in = wsd_pkg::PH_KEY;
               end else if (len7 == '0) begin
                  phase_in = wsd_pkg::PH_HDR0;
               end else begin
                  phase_in = wsd_pkg::PH_DATA;
               end
            end
            wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
               if (left_dec == '0) begin
                  if (mask_ff) begin
                     phase_in = wsd_pkg::PH_KEY;
                  end else if (len_shift == '0) begin
                     phase_in = wsd_pkg::PH_HDR0;
                  end else begin
                     phase_in = wsd_pkg::PH_DATA;
                  end
               end
            end
            wsd_pkg::PH_KEY: begin
               if (left_dec == '0) begin
                  phase_in = (len_ff == '0) ? wsd_pkg::PH_HDR0 : wsd_pkg::PH_DATA;
               end
            end
            wsd_pkg::PH_DATA: begin
               if (data_last) begin
                  phase_in = wsd_pkg::PH_HDR0;
               end
            end
            default: phase_in = wsd_pkg::PH_HDR1;
         endcase
      end
   end

   // datapath and queue push
   always_comb begin
      fin_in  = fin_ff;
      mask_in = mask_ff;
      left_in = left_ff;
      len_in  = len_ff;
      key_in  = key_ff;
      idx_in  = idx_ff;
      err_in  = err_ff;
      push    = 1'b0;
      item    = '0;
      if (in_accept) begin
         unique case (phase_ff)
            wsd_pkg::PH_HDR1: begin
               mask_in = in_byte[7];
               key_in  = '0;
               idx_in  = '0;
               if (len7 == wsd_pkg::Len7Ext16) begin
                  len_in  = '0;
                  left_in = wsd_pkg::Ext16Bytes;
               end else if (len7 == wsd_pkg::Len7Ext64) begin
                  len_in  = '0;
                  left_in = wsd_pkg::Ext64Bytes;
               end else begin
                  len_in = {{(wsd_pkg::LenW-7){1'b0}}, len7};
                  if (in_byte[7]) begin
                     left_in = wsd_pkg::KeyBytes;
                  end else if (len7 == '0) begin
                     push = 1'b1;
                  end
               end
            end
            wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
               len_in  = len_shift;
               left_in = left_dec;
               if (left_dec == '0) begin
                  // length top bit falls out of the 63-bit register here
                  if (phase_ff == wsd_pkg::PH_EXT64 && len_ff[wsd_pkg::LenW-8]) begin
                     err_in = 1'b1;
                  end
                  if (mask_ff) begin
                     left_in = wsd_pkg::KeyBytes;
                  end else if (len_shift == '0) begin
                     push = 1'b1;
                  end
               end
            end
            wsd_pkg::PH_KEY: begin
               key_in  = {key_ff[wsd_pkg::KeyW-9:0], in_byte};
               left_in = left_dec;
               if (left_dec == '0 && len_ff == '0) begin
                  push = 1'b1;
               end
            end
            wsd_pkg::PH_DATA: begin
               idx_in = idx_inc;
               push   = 1'b1;
            end
            default: begin
               fin_in  = in_byte[7];
               mask_in = 1'b0;
               left_in = '0;
               len_in  = '0;
               key_in  = '0;
               idx_in  = '0;
               err_in  = 1'b0;
            end
         endcase

         item.fin_bit      = fin_in;
         item.was_masked   = mask_in;
         item.frame_length = len_in;
         item.length_error = err_in;
         if (phase_ff == wsd_pkg::PH_DATA) begin
            item.data          = in_byte;
            item.key           = key_byte;
            item.has_byte      = 1'b1;
            item.last_in_frame = data_last;
         end else begin
            // empty frame marker
            item.data          = '0;
            item.key           = '0;
            item.has_byte      = 1'b0;
            item.last_in_frame = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= wsd_pkg::PH_HDR0;
         fin_ff   <= 1'b0;
         mask_ff  <= 1'b0;
         left_ff  <= '0;
         err_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         fin_ff   <= fin_in;
         mask_ff  <= mask_in;
         left_ff  <= left_in;
         err_ff   <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff <= len_in;
      key_ff <= key_in;
      idx_ff <= idx_in;
   end

endmodule

`default_nettype wire

// File: hw/rtl/wsd_queue.sv
// short queue of parsed words between the header parser and the unmask stage
// depends on wsd_pkg
`default_nettype none

module wsd_queue #(
   parameter int Depth = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire wsd_pkg::item_type push_item,
   output logic                   full,
   input  wire logic              pop,
   output wsd_pkg::item_type      head_item,
   output logic                   empty
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   wsd_pkg::item_type slot_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign full      = (count_ff == FullCnt);
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/wsd_back.sv
// unmask stage: takes queued words, xors in the key byte and holds the
// result in the output register until it is popped
// depends on wsd_pkg
`default_nettype none

module wsd_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire wsd_pkg::item_type           head_item,
   input  wire logic                        queue_empty,
   output logic                             queue_pop,
   output logic                             out_empty,
   input  wire logic                        out_pop,
   output logic [wsd_pkg::ByteW-1:0]        payload_byte,
   output logic                             has_byte,
   output logic                             fin_bit,
   output logic                             was_masked,
   output logic [wsd_pkg::LenW-1:0]         frame_length,
   output logic                             last_in_frame,
   output logic                             length_error
);

   logic                       valid_ff, valid_in;
   logic [wsd_pkg::ByteW-1:0]  byte_ff, byte_in;
   logic                       has_ff, fin_ff, masked_ff, last_ff, err_ff;
   logic [wsd_pkg::LenW-1:0]   len_ff;
   logic                       load;

   // refill the output register when it is free or being popped
   assign load      = !queue_empty && (!valid_ff || out_pop);
   assign queue_pop = load;
   assign byte_in   = head_item.data ^ head_item.key;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (out_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff   <= byte_in;
         has_ff    <= head_item.has_byte;
         fin_ff    <= head_item.fin_bit;
         masked_ff <= head_item.was_masked;
         len_ff    <= head_item.frame_length;
         last_ff   <= head_item.last_in_frame;
         err_ff    <= head_item.length_error;
      end
   end

   assign out_empty     = !valid_ff;
   assign payload_byte  = byte_ff;
   assign has_byte      = has_ff;
   assign fin_bit       = fin_ff;
   assign was_masked    = masked_ff;
   assign frame_length  = len_ff;
   assign last_in_frame = last_ff;
   assign length_error  = err_ff;

endmodule

`default_nettype wire

// File: hw/rtl/websocket_frame_deframer.sv
// top level of the websocket frame deframer: header parser, word queue and
// unmask stage with output register
// depends on wsd_pkg, wsd_front, wsd_queue, wsd_back
//
//   channel   direction  handshake            words
//   req_      in         req_push / req_full  one stream byte
//   rsp_      out        rsp_pop / rsp_empty  one payload byte or empty-frame marker
//
// takes one stream byte every cycle while req_full is low; header bytes give no word, but the last
// header byte of an empty frame gives a marker. A payload word goes into a queue slot at the accepting
// edge and then into the output register, where it shows on rsp_; it waits while the register is held
// req_full rises only when the output register is held and all QueueDepth queue slots fill
// reset is synchronous: the parser returns to the first header byte and the queue empties
`default_nettype none

module websocket_frame_deframer #(
   parameter int QueueDepth = 4
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_push,
   output logic                             req_full,
   input  wire logic [wsd_pkg::ByteW-1:0]   req_stream_byte,
   output logic                             rsp_empty,
   input  wire logic                        rsp_pop,
   output logic [wsd_pkg::ByteW-1:0]        rsp_payload_byte,
   output logic                             rsp_has_byte,
   output logic                             rsp_fin_bit,
   output logic                             rsp_was_masked,
   output logic [wsd_pkg::LenW-1:0]         rsp_frame_length,
   output logic                             rsp_last_in_frame,
   output logic                             rsp_length_error
);

   logic              accept;
   logic              push;
   wsd_pkg::item_type push_item;
   wsd_pkg::item_type head_item;
   logic              queue_full;
   logic              queue_empty;
   logic              queue_pop;

   assign req_full = queue_full;
   assign accept   = req_push && !queue_full;

   wsd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_accept (accept),
      .in_byte   (req_stream_byte),
      .push      (push),
      .item      (push_item)
   );

   wsd_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (queue_pop),
      .head_item (head_item),
      .empty     (queue_empty)
   );

   wsd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_item     (head_item),
      .queue_empty   (queue_empty),
      .queue_pop     (queue_pop),
      .out_empty     (rsp_empty),
      .out_pop       (rsp_pop),
      .payload_byte  (rsp_payload_byte),
      .has_byte      (rsp_has_byte),
      .fin_bit       (rsp_fin_bit),
      .was_masked    (rsp_was_masked),
      .frame_length  (rsp_frame_length),
      .last_in_frame (rsp_last_in_frame),
      .length_error  (rsp_length_error)
   );

endmodule

`default_nettype wire
